### src/pab_pkg.sv
package pab_pkg;

  // Width of the pixel format register
  localparam int FmtW = 3;

  // Pixel format codes
  localparam logic [FmtW-1:0] FMT_RGB332   = 3'd0;
  localparam logic [FmtW-1:0] FMT_RGB565   = 3'd1;
  localparam logic [FmtW-1:0] FMT_RGBA4444 = 3'd2;
  localparam logic [FmtW-1:0] FMT_RGB888   = 3'd3;
  localparam logic [FmtW-1:0] FMT_RGBA8888 = 3'd4;
  localparam logic [FmtW-1:0] FMT_ABGR8888 = 3'd5;

  // Format in force after reset
  localparam logic [FmtW-1:0] FMT_RESET = FMT_RGBA8888;

  // One pixel split into 8-bit channels
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } chan_t;

  // True for the formats that carry alpha and are blended
  function automatic logic has_alpha(input logic [FmtW-1:0] fmt);
    return (fmt == FMT_RGBA4444) || (fmt == FMT_RGBA8888) || (fmt == FMT_ABGR8888);
  endfunction

  // Expand a nibble to 8 bits: zero stays zero, else fill the low nibble with ones
  function automatic logic [7:0] widen_nibble(input logic [3:0] n);
    return (n == 4'd0) ? 8'd0 : {n, 4'hF};
  endfunction

  // Split a pixel word into channels
  function automatic chan_t unpack_pixel(input logic [FmtW-1:0] fmt, input logic [31:0] w);
    chan_t c;
    if (fmt == FMT_RGBA4444) begin
      c.r = widen_nibble(w[15:12]);
      c.g = widen_nibble(w[11:8]);
      c.b = widen_nibble(w[7:4]);
      c.a = widen_nibble(w[3:0]);
    end else if (fmt == FMT_RGBA8888) begin
      c.r = w[31:24];
      c.g = w[23:16];
      c.b = w[15:8];
      c.a = w[7:0];
    end else begin
      c.r = w[7:0];
      c.g = w[15:8];
      c.b = w[23:16];
      c.a = w[31:24];
    end
    return c;
  endfunction

  // Pack channels back into a pixel word; 4444 keeps the top nibbles
  function automatic logic [31:0] pack_pixel(input logic [FmtW-1:0] fmt, input chan_t c);
    logic [31:0] w;
    if (fmt == FMT_RGBA4444) begin
      w = {16'd0, c.r[7:4], c.g[7:4], c.b[7:4], c.a[7:4]};
    end else if (fmt == FMT_RGBA8888) begin
      w = {c.r, c.g, c.b, c.a};
    end else begin
      w = {c.a, c.b, c.g, c.r};
    end
    return w;
  endfunction

endpackage

### src/pixel_alpha_blend.sv
// Channel       | Direction | Handshake           | Payload
// configuration | in        | pixel_format_we     | pixel_format[2:0]
// pixel pair    | in        | in_valid / in_stall | dst_pixel[31:0], src_pixel[31:0]
// blended pixel | out       | out_valid/out_stall | out_pixel[31:0]
//
// One pixel pair is taken every cycle unless in_stall holds it off; each taken beat is
// held in the input register, blended, and then held in the result register.
// Synchronous active-high reset empties both stages and sets the format to RGBA8888.
// A stall on the output holds the result; the input stage still takes a beat while
// it is empty and stalls only when both stages are full.
module pixel_alpha_blend
  import pab_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_format_we,
  input  logic [FmtW-1:0] pixel_format,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     dst_pixel,
  input  logic [31:0]     src_pixel,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_pixel
);

  logic [FmtW-1:0] cur_format;

  logic            s1_valid;
  logic [FmtW-1:0] s1_fmt;
  logic [31:0]     s1_dst;
  logic [31:0]     s1_src;

  logic            s1_load;
  logic            s2_load;

  chan_t           d_ch;
  chan_t           s_ch;
  chan_t           r_ch;
  logic [8:0]      inv_a;
  logic [15:0]     keep_r, keep_g, keep_b;
  logic [15:0]     add_r, add_g, add_b;
  logic [8:0]      a_sum;
  logic [31:0]     out_pixel_next;

  // Hold the format register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_format <= FMT_RESET;
    end else if (pixel_format_we) begin
      cur_format <= pixel_format;
    end
  end

  // Advance a stage when the one after it is empty or moving on
  assign s2_load  = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_fmt <= cur_format;
      s1_dst <= dst_pixel;
      s1_src <= src_pixel;
    end
  end

  // Source-alpha blend with saturated alpha sum; formats without alpha pass the source
  always_comb begin
    d_ch   = unpack_pixel(s1_fmt, s1_dst);
    s_ch   = unpack_pixel(s1_fmt, s1_src);
    inv_a  = 9'h100 - {1'b0, s_ch.a};
    keep_r = {8'd0, d_ch.r} * {7'd0, inv_a};
    keep_g = {8'd0, d_ch.g} * {7'd0, inv_a};
    keep_b = {8'd0, d_ch.b} * {7'd0, inv_a};
    add_r  = {8'd0, s_ch.r} * {8'd0, s_ch.a};
    add_g  = {8'd0, s_ch.g} * {8'd0, s_ch.a};
    add_b  = {8'd0, s_ch.b} * {8'd0, s_ch.a};
    r_ch.r = keep_r[15:8] + add_r[15:8];
    r_ch.g = keep_g[15:8] + add_g[15:8];
    r_ch.b = keep_b[15:8] + add_b[15:8];
    a_sum  = {1'b0, d_ch.a} + {1'b0, s_ch.a};
    r_ch.a = a_sum[8] ? 8'hFF : a_sum[7:0];
    if (has_alpha(s1_fmt)) begin
      out_pixel_next = pack_pixel(s1_fmt, r_ch);
    end else begin
      out_pixel_next = s1_src;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      out_pixel <= out_pixel_next;
    end
  end

endmodule

### src/pixel_alpha_blend_checker.sv
module pixel_alpha_blend_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [31:0]     out_pixel
);

  // A stalled result beat stays and holds its pixel
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_pixel))
    else $error("stalled result beat changed");

  // Reset empties the result stage
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The input side stalls only when a result is held up at the output
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // A taken beat reaches the output once the output moves
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind pixel_alpha_blend pixel_alpha_blend_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel       (out_pixel)
);

### bench/blend_checker.sv
`timescale 1ns / 100ps

module blend_checker
  import pab_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_format_we,
  input  logic [FmtW-1:0] pixel_format,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [31:0]     dst_pixel,
  input  logic [31:0]     src_pixel,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [31:0]     out_pixel,
  output int              mismatches,
  output int              outstanding
);

  localparam int ReportCap = 20;

  logic [FmtW-1:0] fmt_now;
  logic [31:0]     blended_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fmt_now     = FMT_RESET;
  end

  // Stretch a 4-bit channel to 8 bits; a zero nibble stays dark
  function automatic logic [7:0] stretch_nibble(input logic [3:0] n);
    logic [7:0] wide;
    wide = 8'(n) * 8'd16 + 8'd15;
    return (n == 4'd0) ? 8'h00 : wide;
  endfunction

  // Channels come out as [0]=red, [1]=green, [2]=blue, [3]=alpha
  function automatic logic [3:0][7:0] split_channels(input logic [FmtW-1:0] fmt,
                                                     input logic [31:0] w);
    logic [3:0][7:0] ch;
    if (fmt == FMT_RGBA4444) begin
      ch[0] = stretch_nibble(w[15:12]);
      ch[1] = stretch_nibble(w[11:8]);
      ch[2] = stretch_nibble(w[7:4]);
      ch[3] = stretch_nibble(w[3:0]);
    end else if (fmt == FMT_RGBA8888) begin
      ch[0] = w[31:24];
      ch[1] = w[23:16];
      ch[2] = w[15:8];
      ch[3] = w[7:0];
    end else begin
      ch = w;
    end
    return ch;
  endfunction

  // Expected source-over-destination blend; no-alpha formats return the source
  function automatic logic [31:0] blend_over(input logic [FmtW-1:0] fmt,
                                             input logic [31:0] dst,
                                             input logic [31:0] src);
    logic [3:0][7:0] d;
    logic [3:0][7:0] s;
    logic [3:0][7:0] r;
    logic [16:0]     kept;
    logic [16:0]     added;
    logic [8:0]      alpha_sum;
    if (fmt != FMT_RGBA4444 && fmt != FMT_RGBA8888 && fmt != FMT_ABGR8888)
      return src;
    d = split_channels(fmt, dst);
    s = split_channels(fmt, src);
    for (int i = 0; i < 3; i++) begin
      kept  = (17'(d[i]) * (17'h100 - 17'(s[3]))) >> 8;
      added = (17'(s[i]) * 17'(s[3])) >> 8;
      r[i]  = 8'(kept + added);
    end
    alpha_sum = 9'(d[3]) + 9'(s[3]);
    r[3] = (alpha_sum > 9'd255) ? 8'hFF : alpha_sum[7:0];
    if (fmt == FMT_RGBA4444)
      return {16'h0000, r[0][7:4], r[1][7:4], r[2][7:4], r[3][7:4]};
    if (fmt == FMT_RGBA8888)
      return {r[0], r[1], r[2], r[3]};
    return r;
  endfunction

  // Compare each result beat first, then queue the prediction for each input beat
  always @(posedge clk) begin
    logic [31:0] due;
    if (rst) begin
      fmt_now <= FMT_RESET;
      blended_q.delete();
      outstanding <= 0;
    end else begin
      if (pixel_format_we)
        fmt_now <= pixel_format;
      if (out_valid && !out_stall) begin
        if (blended_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < ReportCap)
            $error("out_pixel: expected nothing, actual %h", out_pixel);
        end else begin
          due = blended_q.pop_front();
          if (out_pixel !== due) begin
            mismatches <= mismatches + 1;
            if (mismatches < ReportCap)
              $error("out_pixel: expected %h, actual %h", due, out_pixel);
          end
        end
      end
      if (in_valid && !in_stall)
        blended_q.push_back(blend_over(fmt_now, dst_pixel, src_pixel));
      outstanding <= blended_q.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pab_pkg::*;

  // Codes outside the defined formats; the block must pass the source word through
  localparam logic [FmtW-1:0] FMT_SPARE6 = 3'd6;
  localparam logic [FmtW-1:0] FMT_SPARE7 = 3'd7;

  localparam int PhaseItems = 120;
  localparam int PhaseCount = 11;
  localparam int CycleLimit = 400000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            pixel_format_we;
  logic [FmtW-1:0] pixel_format;
  logic            in_valid;
  logic            in_stall;
  logic [31:0]     dst_pixel;
  logic [31:0]     src_pixel;
  logic            out_valid;
  logic            out_stall;
  logic [31:0]     out_pixel;

  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  int          pairs_sent = 0;
  int          fmt_writes = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [FmtW-1:0] fmt_cur;

  logic [FmtW-1:0] phase_fmts [PhaseCount] = '{
    FMT_RGB332, FMT_RGB565, FMT_RGBA4444, FMT_RGB888, FMT_RGBA8888, FMT_ABGR8888,
    FMT_SPARE6, FMT_SPARE7, FMT_RGBA4444, FMT_ABGR8888, FMT_RGBA8888
  };

  pixel_alpha_blend uut (
    .clk             (clk),
    .rst             (rst),
    .pixel_format_we (pixel_format_we),
    .pixel_format    (pixel_format),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .dst_pixel       (dst_pixel),
    .src_pixel       (src_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel)
  );

  blend_checker blend_chk (
    .clk             (clk),
    .rst             (rst),
    .pixel_format_we (pixel_format_we),
    .pixel_format    (pixel_format),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .dst_pixel       (dst_pixel),
    .src_pixel       (src_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always #4 clk = ~clk;

  // Count cycles and give up at the limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Back-pressure the result side in styles picked at random: none, light, heavy or runs
  always @(posedge clk) begin
    if (cycles % 256 == 0)
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= cycles[2];
    endcase
  end

  // Present one pixel pair and hold it until taken; open a new burst when one runs out
  task automatic send_pair(input logic [31:0] d, input logic [31:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 64) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    dst_pixel <= d;
    src_pixel <= s;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
  endtask

  // Drain the pipe, let it settle, then load a new format
  task automatic set_format(input logic [FmtW-1:0] f);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    pixel_format    <= f;
    pixel_format_we <= 1'b1;
    @(posedge clk);
    pixel_format_we <= 1'b0;
    fmt_cur = f;
    fmt_writes++;
  endtask

  // Bits that hold alpha in a word of the given format
  function automatic logic [31:0] alpha_bits(input logic [FmtW-1:0] f);
    case (f)
      FMT_RGBA4444: return 32'h0000_000F;
      FMT_RGBA8888: return 32'h0000_00FF;
      default:      return 32'hFF00_0000;
    endcase
  endfunction

  // Random pair, pushed now and then to clear, full or saturating alpha, or dark nibbles
  task automatic random_pair(input logic [FmtW-1:0] f, output logic [31:0] d,
                             output logic [31:0] s);
    logic [31:0] m;
    d = $urandom;
    s = $urandom;
    m = alpha_bits(f);
    case ($urandom_range(0, 7))
      0: s = s & ~m;
      1: s = s | m;
      2: d = d | m;
      3: begin
        for (int i = 0; i < 8; i++) begin
          if ($urandom_range(0, 1) == 0) d[i*4 +: 4] = 4'h0;
          if ($urandom_range(0, 1) == 0) s[i*4 +: 4] = 4'h0;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [31:0] d;
    logic [31:0] s;
    rst             = 1'b1;
    pixel_format_we = 1'b0;
    pixel_format    = FMT_RESET;
    in_valid        = 1'b0;
    dst_pixel       = 32'h0;
    src_pixel       = 32'h0;
    out_stall       = 1'b0;
    fmt_cur         = FMT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // RGBA8888 straight out of reset: extremes, clear and opaque source, alpha saturation
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h1234_5678, 32'h9ABC_DE00);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h8080_8080, 32'h4040_4090);

    // RGBA4444: upper halves ignored, zero against nonzero nibbles, saturation
    set_format(FMT_RGBA4444);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hABCD_1234, 32'hFFFF_5670);
    send_pair(32'h0000_0F0F, 32'h0000_F0FF);
    send_pair(32'h0000_1111, 32'h0000_1111);
    send_pair(32'h0000_00F8, 32'h0000_0009);

    // ABGR8888: alpha in the top byte
    set_format(FMT_ABGR8888);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h00FF_FFFF);
    send_pair(32'h1122_3344, 32'h80AA_BBCC);
    send_pair(32'h9000_0000, 32'h9000_0000);

    // A format without alpha and an undefined code: whole source word passes
    set_format(FMT_RGB332);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'hDEAD_BEEF, 32'h1234_5678);
    set_format(FMT_SPARE7);
    send_pair(32'hFFFF_FFFF, 32'hA5A5_A5A5);

    // Random phases, one per format setting
    for (int p = 0; p < PhaseCount; p++) begin
      set_format(phase_fmts[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        random_pair(fmt_cur, d, s);
        send_pair(d, s);
      end
    end

    // Drain and let the pipe settle before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Blended %0d pixel pairs over %0d format loads, codes 0 to 7 all visited,",
             pairs_sent, fmt_writes);
    $display("with clear, opaque and saturating alpha under bursty input and output stalls.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/pab_pkg.sv
src/pixel_alpha_blend.sv
src/pixel_alpha_blend_checker.sv
bench/blend_checker.sv
bench/testbench.sv
